@@ sv/planar_tile_decoder_with_opacity_macros.svh @@
// Assertion helpers shared by the tile decoder modules.
`ifndef PLANAR_TILE_DECODER_WITH_OPACITY_MACROS_SVH
`define PLANAR_TILE_DECODER_WITH_OPACITY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ptd_pkg.sv @@
`default_nettype none

package ptd_pkg;

  // Depth codes of the configuration register.
  localparam logic [1:0] BPP_2 = 2'd0;
  localparam logic [1:0] BPP_4 = 2'd1;
  localparam logic [1:0] BPP_8 = 2'd2;

  // Tile classification codes.
  localparam logic [1:0] CLASS_MIXED  = 2'd0;
  localparam logic [1:0] CLASS_OPAQUE = 2'd1;
  localparam logic [1:0] CLASS_CLEAR  = 2'd2;

  localparam int ROWS       = 8;
  localparam int ROW_W      = 3;
  localparam int SLOT_W     = 6;
  localparam int LANE_W     = 3;
  localparam int BANK_W     = 1;
  localparam int BUF_ADDR_W = BANK_W + ROW_W;
  localparam int BUF_DEPTH  = 2 ** BUF_ADDR_W;
  localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

  typedef struct packed {
    logic [7:0]  tile_byte;
    logic [11:0] tile_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_0;
    logic [7:0]  pixel_1;
    logic [7:0]  pixel_2;
    logic [7:0]  pixel_3;
    logic [7:0]  pixel_4;
    logic [7:0]  pixel_5;
    logic [7:0]  pixel_6;
    logic [7:0]  pixel_7;
    logic [2:0]  row_number;
    logic [11:0] tile_number;
    logic [1:0]  tile_class;
    logic        last_row;
  } out_item_t;

  // One finished tile waiting for the back end.
  typedef struct packed {
    logic [11:0]       tile_index;
    logic [1:0]        mode;
    logic [BANK_W-1:0] bank;
  } desc_t;

  // Byte write into the row buffer.
  typedef struct packed {
    logic                  en;
    logic [BUF_ADDR_W-1:0] addr;
    logic [LANE_W-1:0]     lane;
    logic [7:0]            data;
  } buf_wr_t;

  // Back end hands a buffer bank back to the front end.
  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } rel_t;

  // Slot of the last byte of a tile at the given depth.
  function automatic logic [SLOT_W-1:0] last_slot(input logic [1:0] mode);
    logic [SLOT_W-1:0] s;
    unique case (mode)
      BPP_2:   s = 6'd15;
      BPP_4:   s = 6'd31;
      default: s = 6'd63;
    endcase
    return s;
  endfunction

  // Number of bit planes at the given depth.
  function automatic logic [3:0] plane_cnt(input logic [1:0] mode);
    logic [3:0] n;
    unique case (mode)
      BPP_2:   n = 4'd2;
      BPP_4:   n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/planar_tile_decoder_with_opacity.sv @@
`default_nettype none
// Planar 8x8 tile decoder with opacity classification.
// Input: one tile byte per transaction, in memory order, taken at a clock edge
// with start high and busy low; tile_index is captured with the last byte.
// A tile is 16, 32 or 64 bytes for a depth of 2, 4 or 8 bits per pixel.
// Config: cfg_data sets the depth; cfg_ready is always high, so a write lands
// at the edge where cfg_valid is high. Write it between tiles.
// Output: each tile gives eight row transactions, top row first, one per cycle,
// each shown for one cycle with out_strobe high. A tile waits in the queue,
// then its rows pass the row buffer read and result registers; the eighth
// row carries last_row and the tile class. The receiver cannot stall the block.
// Throughput: one byte per cycle. The two-bank row buffer lets the next tile
// fill while the back end reads the previous one, so busy rises only when both
// banks still hold tiles that have not been read out, which a tile of at least
// 16 bytes never causes.
// Reset (rst_n low, synchronous) drops partial tiles and pending rows and sets
// the depth to 2 bits per pixel.
module planar_tile_decoder_with_opacity #(
  parameter int MAX_PLANES = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ptd_pkg::in_item_t    in_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_data,
  output logic                 out_strobe,
  output ptd_pkg::out_item_t   out_data
);
  import ptd_pkg::*;

  buf_wr_t                 wr;
  logic                    push;
  desc_t                   push_desc;
  rel_t                    rel;
  logic                    pop;
  desc_t                   q_head;
  logic                    q_empty;
  logic                    rd_en;
  logic [BUF_ADDR_W-1:0]   rd_addr;
  logic [MAX_PLANES*8-1:0] rd_data;

  // Front end: takes bytes, fills the row buffer, closes tiles.
  ptd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .push      (push),
    .push_desc (push_desc),
    .rel       (rel)
  );

  // Finished tiles wait here for the back end.
  ptd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Two banks of eight rows, one byte lane per plane.
  ptd_row_buf #(
    .MAX_PLANES (MAX_PLANES)
  ) u_row_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back end: reads rows, converts to pixels, classifies the tile.
  ptd_back #(
    .MAX_PLANES (MAX_PLANES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ sv/ptd_row_buf.sv @@
`default_nettype none

module ptd_row_buf #(
  parameter int MAX_PLANES = 8
) (
  input  wire                                clk,
  input  ptd_pkg::buf_wr_t                   wr,
  input  wire                                rd_en,
  input  wire [ptd_pkg::BUF_ADDR_W-1:0]      rd_addr,
  output logic [MAX_PLANES*8-1:0]            rd_data
);
  import ptd_pkg::*;

  // One entry per bank and row; each plane byte is a lane of the entry.
  logic [MAX_PLANES*8-1:0] mem [BUF_DEPTH];
  logic [MAX_PLANES*8-1:0] rd_data_r;

  // Byte-lane write and registered read; planes beyond the limit are not stored.
  always_ff @(posedge clk) begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      if (wr.en && (wr.lane == LANE_W'(p))) begin
        mem[wr.addr][p*8 +: 8] <= wr.data;
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/ptd_queue.sv @@
`default_nettype none
`include "planar_tile_decoder_with_opacity_macros.svh"

module ptd_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  ptd_pkg::desc_t  push_desc,
  input  wire             pop,
  output ptd_pkg::desc_t  head,
  output logic            empty
);
  import ptd_pkg::*;

  desc_t       entries_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;
  logic        full;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head  = entries_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  `PTD_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "Tile queue pushed while full.")
  `PTD_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty, "Tile queue popped while empty.")

endmodule

`default_nettype wire

@@ sv/ptd_front.sv @@
`default_nettype none

module ptd_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  ptd_pkg::in_item_t in_data,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [1:0]         cfg_data,
  output ptd_pkg::buf_wr_t  wr,
  output logic              push,
  output ptd_pkg::desc_t    push_desc,
  input  ptd_pkg::rel_t     rel
);
  import ptd_pkg::*;

  logic [1:0]        bpp_mode_r;
  logic [SLOT_W-1:0] byte_count_r;
  logic [SLOT_W-1:0] byte_count_nxt;
  logic [BANK_W-1:0] fill_bank_r;
  logic [1:0]        bank_busy_r;
  logic [1:0]        bank_busy_nxt;
  logic              accept;
  logic              is_last;

  // A byte is taken only while its bank is not held by the back end.
  assign busy      = bank_busy_r[fill_bank_r];
  assign accept    = start && !busy;
  assign is_last   = (byte_count_r >= last_slot(bpp_mode_r));
  assign cfg_ready = 1'b1;

  // The slot gives plane {slot[5:4], slot[0]} and row slot[3:1].
  assign wr.en   = accept;
  assign wr.addr = {fill_bank_r, byte_count_r[3:1]};
  assign wr.lane = {byte_count_r[5:4], byte_count_r[0]};
  assign wr.data = in_data.tile_byte;

  // The last byte closes the tile and hands it to the back end.
  assign push                 = accept && is_last;
  assign push_desc.tile_index = in_data.tile_index;
  assign push_desc.mode       = bpp_mode_r;
  assign push_desc.bank       = fill_bank_r;

  // Bank ownership: set on a finished tile, cleared when the back end is done.
  always_comb begin
    bank_busy_nxt = bank_busy_r;
    if (rel.valid) begin
      bank_busy_nxt[rel.bank] = 1'b0;
    end
    if (push) begin
      bank_busy_nxt[fill_bank_r] = 1'b1;
    end
  end

  // Slot counter.
  always_comb begin
    byte_count_nxt = byte_count_r;
    if (accept) begin
      byte_count_nxt = is_last ? '0 : byte_count_r + SLOT_W'(1);
    end
  end

  // Control registers and the depth register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_mode_r   <= BPP_2;
      byte_count_r <= '0;
      fill_bank_r  <= '0;
      bank_busy_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bpp_mode_r <= cfg_data;
      end
      byte_count_r <= byte_count_nxt;
      bank_busy_r  <= bank_busy_nxt;
      if (push) begin
        fill_bank_r <= ~fill_bank_r;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ptd_back.sv @@
`default_nettype none
`include "planar_tile_decoder_with_opacity_macros.svh"

module ptd_back #(
  parameter int MAX_PLANES = 8
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_empty,
  input  ptd_pkg::desc_t                  q_head,
  output logic                            pop,
  output logic                            rd_en,
  output logic [ptd_pkg::BUF_ADDR_W-1:0]  rd_addr,
  input  wire  [MAX_PLANES*8-1:0]         rd_data,
  output ptd_pkg::rel_t                   rel,
  output logic                            out_strobe,
  output ptd_pkg::out_item_t              out_data
);
  import ptd_pkg::*;

  // Read issue stage.
  logic             active_r;
  logic [ROW_W-1:0] row_r;
  desc_t            desc_r;
  logic             row_done;

  // Pixel stage.
  logic             rdv_r;
  logic [ROW_W-1:0] rd_row_r;
  logic [11:0]      rd_tile_r;
  logic [1:0]       rd_mode_r;
  logic             acc_zero_r;
  logic             acc_set_r;

  // Output register.
  logic             out_strobe_r;
  out_item_t        out_data_r;

  logic [7:0]       pix [8];
  logic [3:0]       planes;
  logic             row_zero;
  logic             row_set;
  logic             tot_zero;
  logic             tot_set;
  logic [1:0]       cls;

  // Take the next tile when idle or while issuing the last row of this one.
  assign row_done = active_r && (row_r == LAST_ROW);
  assign pop      = (!active_r || row_done) && !q_empty;

  assign rd_en     = active_r;
  assign rd_addr   = {desc_r.bank, row_r};
  assign rel.valid = row_done;
  assign rel.bank  = desc_r.bank;

  // Row sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
    end else if (pop) begin
      active_r <= 1'b1;
      row_r    <= '0;
    end else if (active_r) begin
      active_r <= !row_done;
      row_r    <= row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= q_head;
    end
  end

  // Tile fields travel with the row being read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r  <= row_r;
    rd_tile_r <= desc_r.tile_index;
    rd_mode_r <= desc_r.mode;
  end

  // Planar to chunky: pixel c takes bit 7-c of each enabled plane byte.
  assign planes = plane_cnt(rd_mode_r);

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      pix[c] = '0;
      for (int p = 0; p < MAX_PLANES; p++) begin
        if (4'(p) < planes) begin
          pix[c][p] = rd_data[p*8 + 7 - c];
        end
      end
    end
  end

  // Opacity of this row and of the tile so far.
  always_comb begin
    row_zero = 1'b0;
    row_set  = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (pix[c] == 8'd0) begin
        row_zero = 1'b1;
      end else begin
        row_set = 1'b1;
      end
    end
    tot_zero = ((rd_row_r == '0) ? 1'b0 : acc_zero_r) | row_zero;
    tot_set  = ((rd_row_r == '0) ? 1'b0 : acc_set_r) | row_set;
    if (rd_row_r != LAST_ROW) begin
      cls = CLASS_MIXED;
    end else if (!tot_zero) begin
      cls = CLASS_OPAQUE;
    end else if (!tot_set) begin
      cls = CLASS_CLEAR;
    end else begin
      cls = CLASS_MIXED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_zero_r   <= 1'b0;
      acc_set_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (rdv_r) begin
        acc_zero_r <= tot_zero;
        acc_set_r  <= tot_set;
      end
      out_strobe_r <= rdv_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    out_data_r.pixel_0     <= pix[0];
    out_data_r.pixel_1     <= pix[1];
    out_data_r.pixel_2     <= pix[2];
    out_data_r.pixel_3     <= pix[3];
    out_data_r.pixel_4     <= pix[4];
    out_data_r.pixel_5     <= pix[5];
    out_data_r.pixel_6     <= pix[6];
    out_data_r.pixel_7     <= pix[7];
    out_data_r.row_number  <= rd_row_r;
    out_data_r.tile_number <= rd_tile_r;
    out_data_r.tile_class  <= cls;
    out_data_r.last_row    <= (rd_row_r == LAST_ROW);
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `PTD_ASSERT_NEXT(a_rows_in_order, clk, rst_n, out_strobe_r && !out_data_r.last_row, out_strobe_r && (out_data_r.row_number == ($past(out_data_r.row_number) + 3'd1)), "Tile rows not delivered in consecutive cycles.")
  `PTD_ASSERT_IMP(a_class_on_last, clk, rst_n, out_strobe_r && !out_data_r.last_row, out_data_r.tile_class == CLASS_MIXED, "Tile class set before the last row.")

endmodule

`default_nettype wire
